// ----- hdl/monomial_exponent_enumerator_core_macros.svh -----
// Assertion macros for the monomial exponent enumerator.
`ifndef MONOMIAL_EXPONENT_ENUMERATOR_CORE_MACROS_SVH
`define MONOMIAL_EXPONENT_ENUMERATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MEE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MEE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mee_pkg.sv -----
// Shared types and constants of the monomial exponent enumerator.
package mee_pkg;

    localparam int MAX_VARS_DEF = 8;
    localparam int EXP_BITS_DEF = 8;

    localparam int MAX_RESULTS = 8;
    localparam int OUT_EXP_W   = 8;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int POS_W       = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int VARS_W     = 4;

    localparam logic [VARS_W-1:0] VARS_RESET = 4'd3;
    localparam logic [POS_W-1:0]  LEN_RESET  = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VARS_IN_USE,
        CFG_SEQ_LENGTH
    } t_cfg_reg;

    // One monomial as handed from the front to the back.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][OUT_EXP_W-1:0] exps;
        logic [CNT_W-1:0]                      n_vars;
        logic                                  fin;
        logic                                  ovf;
    } t_mono;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- hdl/mee_req_if.sv -----
// Request channel: valid/ready handshake with the restart flag.
interface mee_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// ----- hdl/mee_res_if.sv -----
// Result channel: valid/ready handshake with one exponent per item.
interface mee_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] var_index;
    logic [7:0] exponent;
    logic       last_of_vector;
    logic       final_monomial;
    logic       overflow;

    modport source (output valid, output var_index, output exponent,
                    output last_of_vector, output final_monomial, output overflow,
                    input ready);
    modport sink   (input valid, input var_index, input exponent,
                    input last_of_vector, input final_monomial, input overflow,
                    output ready);
endinterface

// ----- hdl/mee_front.sv -----
// Front: configuration, exponent state and the graded advance step.
module mee_front import mee_pkg::*; #(
    parameter int MAX_VARS = MAX_VARS_DEF,
    parameter int EXP_BITS = EXP_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mee_req_if.sink               req,
    input  t_q_stat               i_qstat,
    output logic                  o_push,
    output t_mono                 o_push_data
);

    localparam int ACT_MAX = (MAX_VARS < MAX_RESULTS) ? MAX_VARS : MAX_RESULTS;
    localparam int SLOT_W  = (ACT_MAX > 1) ? $clog2(ACT_MAX) : 1;

    logic [EXP_BITS-1:0] r_exp [ACT_MAX];
    logic [EXP_BITS-1:0] n_exp [ACT_MAX];
    logic [EXP_BITS-1:0] r_deg, n_deg;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [VARS_W-1:0]   r_vars, n_vars;
    logic [POS_W-1:0]    r_len, n_len;

    logic [CNT_W-1:0]    nv;
    logic [SLOT_W-1:0]   nv_last;
    logic [POS_W-1:0]    len_m1;
    logic [EXP_BITS-1:0] carry;
    logic                found;
    logic [SLOT_W-1:0]   j_idx;
    logic [SLOT_W-1:0]   j_m1;
    logic                accept;
    logic                ovf;

    assign req.ready = !i_qstat.full;
    assign accept    = req.valid && req.ready;

    always_comb begin
        if (r_vars == '0) begin
            nv = CNT_W'(1);
        end else if (r_vars > VARS_W'(ACT_MAX)) begin
            nv = CNT_W'(ACT_MAX);
        end else begin
            nv = CNT_W'(r_vars);
        end
    end

    assign nv_last = SLOT_W'(nv - CNT_W'(1));
    assign len_m1  = (r_len == '0) ? '0 : r_len - POS_W'(1);
    assign carry   = r_exp[0] + EXP_BITS'(1);

    // first nonzero exponent above variable 0
    always_comb begin
        found = 1'b0;
        j_idx = '0;
        for (int k = 1; k < ACT_MAX; k++) begin
            if (!found && CNT_W'(k) < nv && r_exp[k] != '0) begin
                found = 1'b1;
                j_idx = SLOT_W'(k);
            end
        end
    end

    assign j_m1 = j_idx - SLOT_W'(1);

    always_comb begin
        n_exp  = r_exp;
        n_deg  = r_deg;
        n_pos  = r_pos;
        n_vars = r_vars;
        n_len  = r_len;
        ovf    = 1'b0;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_VARS_IN_USE: begin
                    n_vars = i_cfg_data[VARS_W-1:0];
                    for (int k = 0; k < ACT_MAX; k++) begin
                        n_exp[k] = '0;
                    end
                    n_deg = '0;
                    n_pos = '0;
                end
                CFG_SEQ_LENGTH: n_len = i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end else if (accept) begin
            if (req.restart || r_pos >= len_m1) begin
                for (int k = 0; k < ACT_MAX; k++) begin
                    n_exp[k] = '0;
                end
                n_deg = '0;
                n_pos = '0;
            end else if (!found) begin
                if (r_deg == '1) begin
                    ovf = 1'b1;
                end else begin
                    // degree rise: all of x[0]+1 moves to the last variable
                    for (int k = 0; k < ACT_MAX; k++) begin
                        n_exp[k] = (SLOT_W'(k) == nv_last) ? carry : '0;
                    end
                    n_deg = r_deg + EXP_BITS'(1);
                    n_pos = r_pos + POS_W'(1);
                end
            end else begin
                for (int k = 0; k < ACT_MAX; k++) begin
                    if (SLOT_W'(k) == j_idx) begin
                        n_exp[k] = r_exp[k] - EXP_BITS'(1);
                    end else if (SLOT_W'(k) == j_m1) begin
                        n_exp[k] = ((k == 0) ? '0 : r_exp[k]) + carry;
                    end else if (k == 0) begin
                        n_exp[k] = '0;
                    end
                end
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_comb begin
        o_push_data      = '0;
        for (int k = 0; k < ACT_MAX; k++) begin
            o_push_data.exps[k] = OUT_EXP_W'(n_exp[k]);
        end
        o_push_data.n_vars = nv;
        o_push_data.fin    = (n_pos == len_m1);
        o_push_data.ovf    = ovf;
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ACT_MAX; k++) begin
                r_exp[k] <= '0;
            end
            r_deg  <= '0;
            r_pos  <= '0;
            r_vars <= VARS_RESET;
            r_len  <= LEN_RESET;
        end else begin
            r_exp  <= n_exp;
            r_deg  <= n_deg;
            r_pos  <= n_pos;
            r_vars <= n_vars;
            r_len  <= n_len;
        end
    end

endmodule

// ----- hdl/mee_queue.sv -----
// Two-entry queue of monomials between front and back.
module mee_queue import mee_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_mono   i_push_data,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_mono   o_head
);

    t_mono      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- hdl/mee_back.sv -----
// Back: walks the head monomial out one variable per result item.
module mee_back import mee_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_qstat,
    input  t_mono   i_head,
    output logic    o_pop,
    mee_res_if.source res
);

    logic [IDX_W-1:0] r_slot;
    logic             last;
    logic             fire;

    assign last = (CNT_W'(r_slot) == i_head.n_vars - CNT_W'(1));
    assign fire = res.valid && res.ready;

    assign res.valid          = !i_qstat.empty;
    assign res.var_index      = r_slot;
    assign res.exponent       = i_head.exps[r_slot];
    assign res.last_of_vector = last;
    assign res.final_monomial = i_head.fin;
    assign res.overflow       = i_head.ovf;

    assign o_pop = fire && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (fire) begin
            r_slot <= last ? '0 : r_slot + IDX_W'(1);
        end
    end

endmodule

// ----- hdl/monomial_exponent_enumerator_core.sv -----
// Top level of the graded monomial exponent enumerator.
// Each request item on i_req either restarts (restart = 1) at the constant
// monomial or advances the held exponent vector to the next monomial in
// graded order. The block answers with one result item per variable in use
// on o_res, in variable order, last_of_vector on the final one; every item
// of a monomial carries its final_monomial and overflow flags.
// A request is taken by the front, which updates the vector and writes the
// monomial into a two-entry queue. The first result item can be taken the
// cycle after the request; the rest follow one per cycle while o_res.ready
// is high. The single result lane of the back end limits throughput: one item
// per variable in use (1..8) for each request. Requests keep being taken while
// results wait, until the queue holds two monomials.
// Configuration: i_cfg_we with i_cfg_index 0 (vars_in_use, clears the vector)
// or 1 (sequence_length), data on i_cfg_data; write only while idle.
// Reset (i_rst_n low, synchronous) clears the vector and the queue and loads
// vars_in_use = 3 and sequence_length = 10. If o_res.ready is low the current
// result item holds and the front stalls once the queue is full.
`include "monomial_exponent_enumerator_core_macros.svh"

module monomial_exponent_enumerator_core import mee_pkg::*; #(
    parameter int MAX_VARS = MAX_VARS_DEF,
    parameter int EXP_BITS = EXP_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mee_req_if.sink               i_req,
    mee_res_if.source             o_res
);

    t_q_stat w_qstat;
    t_mono   w_push_data;
    t_mono   w_head;
    logic    w_push;
    logic    w_pop;

    mee_front #(
        .MAX_VARS (MAX_VARS),
        .EXP_BITS (EXP_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .req         (i_req),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    mee_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_stat      (w_qstat),
        .o_head      (w_head)
    );

    mee_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (w_qstat),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .res     (o_res)
    );

    `MEE_ASSERT_IMP(a_full_blocks_req, w_qstat.full, !i_req.ready, "request taken with full queue")
    `MEE_ASSERT_IMP(a_ovf_not_final, o_res.valid && o_res.overflow, !o_res.final_monomial, "overflow on final monomial")
    `MEE_ASSERT_NXT(a_index_steps, o_res.valid && o_res.ready && !o_res.last_of_vector, o_res.valid && o_res.var_index == 3'($past(o_res.var_index) + 3'd1), "result index did not step")

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the graded monomial exponent enumerator: directed table, then random.
module tb_top;
    import mee_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 88;
    localparam int END_HOLDOFF  = 20;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // One table row: a request or a register write, with an optional typed-in monomial.
    typedef struct packed {
        t_row_kind             kind;
        t_cfg_reg              reg_sel;
        logic [CFG_DATA_W-1:0] data;
        logic                  restart;
        logic                  typed;
        logic [63:0]           exps;
        logic                  fin;
        logic                  ovf;
    } t_dir_row;

    typedef struct packed {
        logic [IDX_W-1:0]     idx;
        logic [OUT_EXP_W-1:0] expo;
        logic                 last;
        logic                 fin;
        logic                 ovf;
    } t_exp_item;

    localparam logic [63:0] MONO_ZERO = 64'h0;

    localparam t_dir_row DIR_TABLE [28] = '{
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b1, 1'b1, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b1, 64'h0000000000010000, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        // past the end of the sequence: wraps to the constant monomial
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b1, MONO_ZERO, 1'b0, 1'b0},
        // zero length acts as one: every item is the constant and final
        '{ROW_CFG, CFG_SEQ_LENGTH,  16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b1, MONO_ZERO, 1'b1, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b1, 1'b1, MONO_ZERO, 1'b1, 1'b0},
        '{ROW_CFG, CFG_SEQ_LENGTH,  16'h0005, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        // zero variables acts as one; upper data bits are dropped
        '{ROW_CFG, CFG_VARS_IN_USE, 16'hFFF0, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        // count above the limit clamps to eight variables
        '{ROW_CFG, CFG_VARS_IN_USE, 16'h000F, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_CFG, CFG_SEQ_LENGTH,  16'hFFFF, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b1, 64'h0100000000000000, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        // shorten the sequence below the current position
        '{ROW_CFG, CFG_SEQ_LENGTH,  16'h0002, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b1, MONO_ZERO, 1'b0, 1'b0},
        '{ROW_REQ, CFG_VARS_IN_USE, 16'h0000, 1'b0, 1'b0, MONO_ZERO, 1'b0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mee_req_if req_ch();
    mee_res_if res_ch();

    monomial_exponent_enumerator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [OUT_EXP_W-1:0]  mono_exp [MAX_VARS_DEF];
    logic [7:0]            mono_deg;
    logic [POS_W-1:0]      mono_pos;
    logic [VARS_W-1:0]     reg_vars;
    logic [POS_W-1:0]      reg_len;
    logic                  pred_fin;
    logic                  pred_ovf;

    t_exp_item pending_exps [$];
    t_exp_item want;

    int errors;
    int req_count;
    int res_count;
    int ovf_seen;
    int fin_seen;
    int cycle_count;
    int burst_left;

    function automatic int unsigned used_vars();
        int unsigned n;
        n = reg_vars;
        if (n < 1) n = 1;
        if (n > MAX_VARS_DEF) n = MAX_VARS_DEF;
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        return n;
    endfunction

    function automatic int unsigned used_len();
        return (reg_len == '0) ? 1 : int'(reg_len);
    endfunction

    function automatic void clear_monomial();
        for (int k = 0; k < MAX_VARS_DEF; k++) mono_exp[k] = '0;
        mono_deg = '0;
        mono_pos = '0;
    endfunction

    // Steps the held monomial the way the block does and leaves the flags in pred_*.
    function automatic void advance_monomial(input logic restart);
        int unsigned n;
        int unsigned len;
        int unsigned j;
        logic [8:0]  carry;
        n = used_vars();
        len = used_len();
        j = 0;
        pred_ovf = 1'b0;
        if (restart || int'(mono_pos) >= len - 1) begin
            clear_monomial();
        end else begin
            for (int i = 1; i < n; i++) begin
                if (j == 0 && mono_exp[i] != '0) j = i;
            end
            if (j == 0) begin
                // degree raise, refused at the top degree
                if (mono_deg == 8'hFF) begin
                    pred_ovf = 1'b1;
                end else begin
                    carry = {1'b0, mono_exp[0]} + 9'd1;
                    mono_exp[0] = '0;
                    mono_exp[n-1] = carry[7:0];
                    mono_deg = mono_deg + 8'd1;
                end
            end else begin
                carry = {1'b0, mono_exp[0]} + 9'd1;
                mono_exp[j] = mono_exp[j] - 8'd1;
                mono_exp[0] = '0;
                mono_exp[j-1] = mono_exp[j-1] + carry[7:0];
            end
            if (!pred_ovf) mono_pos = mono_pos + 16'd1;
        end
        pred_fin = (int'(mono_pos) == len - 1);
    endfunction

    function automatic logic [63:0] packed_monomial();
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < MAX_VARS_DEF; k++) v[8*k +: 8] = mono_exp[k];
        return v;
    endfunction

    function automatic void queue_monomial(input logic [63:0] exps, input logic fin,
                                           input logic ovf);
        int unsigned n;
        t_exp_item item;
        n = used_vars();
        for (int k = 0; k < n; k++) begin
            item.idx  = k[IDX_W-1:0];
            item.expo = exps[8*k +: 8];
            item.last = (k == n - 1);
            item.fin  = fin;
            item.ovf  = ovf;
            pending_exps.insert(pending_exps.size(), item);
        end
    endfunction

    task automatic send_request(input logic restart, input logic typed,
                                input logic [63:0] exps, input logic fin, input logic ovf);
        @(negedge i_clk);
        req_ch.valid = 1'b1;
        req_ch.restart = restart;
        do @(posedge i_clk); while (!req_ch.ready);
        req_count++;
        advance_monomial(restart);
        if (typed) queue_monomial(exps, fin, ovf);
        else queue_monomial(packed_monomial(), pred_fin, pred_ovf);
        // sender bursts: drop valid for a while once the burst runs out
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            req_ch.restart = 1'($urandom_range(0, 1));
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 20 : int'($urandom_range(0, 6));
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        req_ch.restart = 1'($urandom_range(0, 1));
        while (pending_exps.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = sel;
        i_cfg_data = data;
        @(posedge i_clk);
        if (sel == CFG_VARS_IN_USE) begin
            reg_vars = data[VARS_W-1:0];
            clear_monomial();
        end else begin
            reg_len = data;
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Receiver: stretches of always-ready, random stalls and heavy stalls.
    initial begin
        int mode;
        res_ch.ready = 1'b0;
        forever begin
            mode = int'($urandom_range(0, 2));
            repeat ($urandom_range(5, 40)) begin
                @(negedge i_clk);
                case (mode)
                    0: res_ch.ready = 1'b1;
                    1: res_ch.ready = 1'($urandom_range(0, 1));
                    default: res_ch.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic compare_field(input string name, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            res_count++;
            if (pending_exps.size() == 0) begin
                errors++;
                $error("result item with nothing expected: var_index %0d exponent %0d",
                       res_ch.var_index, res_ch.exponent);
            end else begin
                want = pending_exps.pop_front();
                compare_field("var_index", 8'(want.idx), 8'(res_ch.var_index));
                compare_field("exponent", want.expo, res_ch.exponent);
                compare_field("last_of_vector", 8'(want.last), 8'(res_ch.last_of_vector));
                compare_field("final_monomial", 8'(want.fin), 8'(res_ch.final_monomial));
                compare_field("overflow", 8'(want.ovf), 8'(res_ch.overflow));
                if (want.last && want.ovf) ovf_seen++;
                if (want.last && want.fin) fin_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        int random_sent;
        int phase_items;
        logic [CFG_DATA_W-1:0] len_pick;
        logic [CFG_DATA_W-1:0] vars_pick;
        errors = 0;
        req_count = 0;
        res_count = 0;
        ovf_seen = 0;
        fin_seen = 0;
        cycle_count = 0;
        burst_left = 0;
        random_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_VARS_IN_USE;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.restart = 1'b0;
        reg_vars = VARS_RESET;
        reg_len = LEN_RESET;
        clear_monomial();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < $size(DIR_TABLE); r++) begin
            if (DIR_TABLE[r].kind == ROW_CFG) begin
                drain();
                write_reg(DIR_TABLE[r].reg_sel, DIR_TABLE[r].data);
            end else begin
                send_request(DIR_TABLE[r].restart, DIR_TABLE[r].typed, DIR_TABLE[r].exps,
                             DIR_TABLE[r].fin, DIR_TABLE[r].ovf);
            end
        end

        while (random_sent < RANDOM_ITEMS) begin
            drain();
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 9))
                    0: vars_pick = {12'($urandom), 4'd0};
                    1: vars_pick = {12'($urandom), 4'($urandom_range(9, 15))};
                    default: vars_pick = {12'($urandom), 4'($urandom_range(1, 8))};
                endcase
                write_reg(CFG_VARS_IN_USE, vars_pick);
            end
            case ($urandom_range(0, 9))
                0: len_pick = 16'd0;
                1: len_pick = 16'hFFFF;
                2: len_pick = 16'($urandom);
                default: len_pick = 16'($urandom_range(1, 30));
            endcase
            write_reg(CFG_SEQ_LENGTH, len_pick);
            phase_items = int'($urandom_range(10, 30));
            for (int i = 0; i < phase_items && random_sent < RANDOM_ITEMS; i++) begin
                send_request($urandom_range(0, 15) == 0, 1'b0, MONO_ZERO, 1'b0, 1'b0);
                random_sent++;
                // hold off now and then until the block has caught up
                if ($urandom_range(0, 40) == 0) drain();
            end
        end

        drain();
        repeat (END_HOLDOFF) @(posedge i_clk);
        if (pending_exps.size() != 0) begin
            errors++;
            $error("%0d expected result items never arrived", pending_exps.size());
        end
        $display("tb_top: %0d requests (%0d random), %0d result items checked",
                 req_count, random_sent, res_count);
        $display("tb_top: %0d refused advances, %0d sequence-final monomials seen",
                 ovf_seen, fin_seen);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/mee_pkg.sv
hdl/mee_req_if.sv
hdl/mee_res_if.sv
hdl/mee_front.sv
hdl/mee_queue.sv
hdl/mee_back.sv
hdl/monomial_exponent_enumerator_core.sv
tb/sv/tb_top.sv
